FILE: design/video_field_deinterlacer_unit_defines.svh
// Assertion helpers used by the checker of this block.
`ifndef VIDEO_FIELD_DEINTERLACER_UNIT_DEFINES_SVH
`define VIDEO_FIELD_DEINTERLACER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define VFD_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vfd check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define VFD_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vfd check failed");

`endif

FILE: design/vfd_pkg.sv
package vfd_pkg;

	localparam int MAX_WIDTH   = 2048;
	localparam int MAX_HEIGHT  = 2048;
	localparam int SAMPLE_BITS = 16;

	localparam int COMP_W = 16;
	localparam int PIX_W  = 4 * COMP_W;
	localparam int ADDR_W = $clog2(MAX_WIDTH);
	localparam int COL_W  = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
	localparam int POS_W  = 11;

	localparam int MODE_W     = 2;
	localparam int CC_W       = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [COMP_W-1:0] SAMPLE_MASK = COMP_W'((1 << SAMPLE_BITS) - 1);
	localparam logic [CC_W-1:0]   CC_RESET    = CC_W'(4);
	localparam logic [CC_W-1:0]   CC_FULL     = CC_W'(4);

	localparam logic [CFG_IDX_W-1:0] REG_MODE       = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COMP_COUNT = CFG_IDX_W'(1);

	typedef enum logic [MODE_W-1:0] {
		MODE_EVEN = 2'd0,
		MODE_ODD  = 2'd1,
		MODE_AVG  = 2'd2,
		MODE_SWAP = 2'd3
	} mode_t;

	// what an accepted pixel turns into
	typedef enum logic [2:0] {
		K_NONE  = 3'd0,
		K_PREV2 = 3'd1,
		K_CUR2  = 3'd2,
		K_MEAN2 = 3'd3,
		K_SWAP1 = 3'd4,
		K_SWAP2 = 3'd5
	} kind_t;

	// one or two output pixels; rows are row-1 then row
	typedef struct packed {
		logic [PIX_W-1:0] pix0;
		logic [PIX_W-1:0] pix1;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             two;
	} job_t;

	function automatic logic [PIX_W-1:0] mean_pix(input logic [PIX_W-1:0] x,
			input logic [PIX_W-1:0] y);
		logic [PIX_W-1:0]  r;
		logic [COMP_W:0]   s;
		r = '0;
		for (int k = 0; k < 4; k++) begin
			s = {1'b0, x[k*COMP_W +: COMP_W]} + {1'b0, y[k*COMP_W +: COMP_W]};
			r[k*COMP_W +: COMP_W] = s[COMP_W:1];
		end
		return r;
	endfunction

endpackage

FILE: design/vfd_front.sv
module vfd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [vfd_pkg::COMP_W-1:0]    comp_a,
	input  logic [vfd_pkg::COMP_W-1:0]    comp_b,
	input  logic [vfd_pkg::COMP_W-1:0]    comp_c,
	input  logic [vfd_pkg::COMP_W-1:0]    comp_d,
	input  logic                          row_end,
	input  logic                          final_row,
	input  vfd_pkg::mode_t                mode,
	input  logic [vfd_pkg::CC_W-1:0]      comp_count,
	input  logic                          q_full,
	output logic                          job_push,
	output vfd_pkg::job_t                 job
);
	import vfd_pkg::*;

	logic [PIX_W-1:0] line_mem [MAX_WIDTH];

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic             s1_vld_q;
	kind_t            kind_s1;
	logic [PIX_W-1:0] cur_s1;
	logic [PIX_W-1:0] prev_s1;
	logic [POS_W-1:0] row_s1;
	logic [POS_W-1:0] col_s1;

	logic             accept;
	logic             in_bounds;
	logic             odd_row;
	logic [COMP_W-1:0] d_in;
	logic [PIX_W-1:0] cur;
	kind_t            kind;
	logic [PIX_W-1:0] mean;

	assign job_push = s1_vld_q && (kind_s1 != K_NONE) && !q_full;
	assign in_stall = s1_vld_q && (kind_s1 != K_NONE) && q_full;
	assign accept   = in_valid && !in_stall;

	assign d_in = (comp_count >= CC_FULL) ? (comp_d & SAMPLE_MASK) : '0;
	assign cur  = {d_in, comp_c & SAMPLE_MASK, comp_b & SAMPLE_MASK, comp_a & SAMPLE_MASK};

	assign in_bounds = (col_q < COL_W'(MAX_WIDTH)) && (row_q < ROW_W'(MAX_HEIGHT));
	assign odd_row   = row_q[0];

	always_comb begin
		kind = K_NONE;
		if (in_bounds) begin
			case (mode)
				MODE_EVEN: kind = odd_row ? K_PREV2 : K_NONE;
				MODE_ODD:  kind = odd_row ? K_CUR2 : K_NONE;
				MODE_AVG:  kind = odd_row ? K_MEAN2 : K_NONE;
				MODE_SWAP: begin
					if (row_q != '0)
						kind = final_row ? K_SWAP2 : K_SWAP1;
				end
				default:   kind = K_NONE;
			endcase
		end
	end

	// line store: old value read and new value written at the same column
	always_ff @(posedge clk) begin
		if (accept && in_bounds) begin
			prev_s1 <= line_mem[col_q[ADDR_W-1:0]];
			line_mem[col_q[ADDR_W-1:0]] <= cur;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			cur_s1  <= cur;
			row_s1  <= row_q[POS_W-1:0];
			col_s1  <= col_q[POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			if (accept)
				s1_vld_q <= 1'b1;
			else if (!in_stall)
				s1_vld_q <= 1'b0;
			if (accept) begin
				if (row_end) begin
					col_q <= '0;
					if (final_row)
						row_q <= '0;
					else if (row_q < ROW_W'(MAX_HEIGHT))
						row_q <= row_q + 1'b1;
				end else if (col_q < COL_W'(MAX_WIDTH)) begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	assign mean = mean_pix(prev_s1, cur_s1);

	always_comb begin
		job.row  = row_s1;
		job.col  = col_s1;
		job.two  = (kind_s1 != K_SWAP1);
		job.pix0 = cur_s1;
		job.pix1 = cur_s1;
		case (kind_s1)
			K_PREV2: begin
				job.pix0 = prev_s1;
				job.pix1 = prev_s1;
			end
			K_MEAN2: begin
				job.pix0 = mean;
				job.pix1 = mean;
			end
			K_SWAP2: job.pix1 = prev_s1;
			default: job.pix1 = cur_s1;
		endcase
	end

endmodule

FILE: design/vfd_queue.sv
module vfd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  vfd_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output vfd_pkg::job_t head
);
	import vfd_pkg::*;

	job_t              slots [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slots[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slots[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: design/vfd_back.sv
module vfd_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       head_valid,
	input  vfd_pkg::job_t              head,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [vfd_pkg::COMP_W-1:0] res_a,
	output logic [vfd_pkg::COMP_W-1:0] res_b,
	output logic [vfd_pkg::COMP_W-1:0] res_c,
	output logic [vfd_pkg::COMP_W-1:0] res_d,
	output logic [vfd_pkg::POS_W-1:0]  out_row,
	output logic [vfd_pkg::POS_W-1:0]  out_col,
	output logic                       run_last
);
	import vfd_pkg::*;

	logic             phase_q;
	logic             out_vld_q;
	logic [PIX_W-1:0] pix_q;
	logic [POS_W-1:0] row_q;
	logic [POS_W-1:0] col_q;
	logic             last_q;

	logic             load;
	logic             last;

	assign load = head_valid && (!out_vld_q || !out_stall);
	assign last = !head.two || phase_q;
	assign pop  = load && last;

	always_ff @(posedge clk) begin
		if (load) begin
			pix_q  <= phase_q ? head.pix1 : head.pix0;
			row_q  <= phase_q ? head.row : head.row - 1'b1;
			col_q  <= head.col;
			last_q <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (load)
				phase_q <= !last;
			if (load)
				out_vld_q <= 1'b1;
			else if (!out_stall)
				out_vld_q <= 1'b0;
		end
	end

	assign out_valid = out_vld_q;
	assign res_a     = pix_q[0*COMP_W +: COMP_W];
	assign res_b     = pix_q[1*COMP_W +: COMP_W];
	assign res_c     = pix_q[2*COMP_W +: COMP_W];
	assign res_d     = pix_q[3*COMP_W +: COMP_W];
	assign out_row   = row_q;
	assign out_col   = col_q;
	assign run_last  = last_q;

endmodule

FILE: design/video_field_deinterlacer_unit.sv
// Line-doubling / blending deinterlacer on a raster pixel stream. The front
// stage takes one pixel per cycle unless in_stall holds it, reads and
// rewrites the one-line store (2048 x 64 bits, a single read-before-write
// port) and sorts the pixel into zero, one or two output pixels; a four-entry
// queue holds the pending work and the back stage, unless out_stall holds it,
// sends one output pixel per cycle through a registered output. An odd row in
// even, odd or average mode, and a final row in swap mode, yield two results,
// sent in turn by the single output port; rows that yield one or no result run
// at one cycle per pixel if not stalled. A pixel's first result passes the
// front stage registers, a queue slot and the output register. The line store
// has no reset: a row longer than the row before it reads undefined data.
// Configuration (mode, component count) must be written while the block is idle.
module video_field_deinterlacer_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [vfd_pkg::COMP_W-1:0]     comp_a,
	input  logic [vfd_pkg::COMP_W-1:0]     comp_b,
	input  logic [vfd_pkg::COMP_W-1:0]     comp_c,
	input  logic [vfd_pkg::COMP_W-1:0]     comp_d,
	input  logic                           row_end,
	input  logic                           final_row,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [vfd_pkg::COMP_W-1:0]     res_a,
	output logic [vfd_pkg::COMP_W-1:0]     res_b,
	output logic [vfd_pkg::COMP_W-1:0]     res_c,
	output logic [vfd_pkg::COMP_W-1:0]     res_d,
	output logic [vfd_pkg::POS_W-1:0]      out_row,
	output logic [vfd_pkg::POS_W-1:0]      out_col,
	output logic                           run_last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [vfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vfd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import vfd_pkg::*;

	mode_t           mode_q;
	logic [CC_W-1:0] cc_q;

	logic q_full;
	logic job_push;
	job_t job;
	logic pop;
	logic head_valid;
	job_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_EVEN;
			cc_q   <= CC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:       mode_q <= mode_t'(cfg_data[MODE_W-1:0]);
				REG_COMP_COUNT: cc_q   <= cfg_data[CC_W-1:0];
				default:        ;
			endcase
		end
	end

	vfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.comp_a     (comp_a),
		.comp_b     (comp_b),
		.comp_c     (comp_c),
		.comp_d     (comp_d),
		.row_end    (row_end),
		.final_row  (final_row),
		.mode       (mode_q),
		.comp_count (cc_q),
		.q_full     (q_full),
		.job_push   (job_push),
		.job        (job)
	);

	vfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_job   (job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	vfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.res_a      (res_a),
		.res_b      (res_b),
		.res_c      (res_c),
		.res_d      (res_d),
		.out_row    (out_row),
		.out_col    (out_col),
		.run_last   (run_last)
	);

endmodule

FILE: design/vfd_checker.sv
`include "video_field_deinterlacer_unit_defines.svh"

module vfd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [vfd_pkg::COMP_W-1:0]     res_a,
	input logic [vfd_pkg::POS_W-1:0]      out_row,
	input logic [vfd_pkg::POS_W-1:0]      out_col,
	input logic                           run_last
);

	// a held result keeps res_a, its row and its run_last flag
	`VFD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(res_a) && $stable(out_row) && $stable(run_last))

	// the second result of a pair follows right after the first transaction
	`VFD_ASSERT_NEXT(a_pair_next, out_valid && !out_stall && !run_last, out_valid)

	// both results of a pair share a column and sit on adjacent rows
	`VFD_ASSERT_NEXT(a_pair_pos, out_valid && !out_stall && !run_last, out_col == $past(out_col) && out_row == $past(out_row) + 1'b1)

endmodule

bind video_field_deinterlacer_unit vfd_checker u_vfd_checker (.*);
